// ===== sv/mpms_pkg.sv =====
// ----------------------------------------------------------------------------
// mpms_pkg
// Widths, weights, register indexes and result type of the masked
// patch-match selection block.
// ----------------------------------------------------------------------------
package mpms_pkg;

  localparam int PIX_W  = 16;
  localparam int POS_W  = 24;
  localparam int DIFF_W = 47;
  localparam int WGT_W  = 15;
  localparam int DIST_W = 32;
  localparam int FAC_W  = 16;
  localparam int NSIM_W = 7;
  localparam int RANK_W = 6;
  localparam int PROD_W = FAC_W + DIST_W;
  localparam int THR_W  = PROD_W - 8;

  localparam int          DIV_STEPS  = DIFF_W;
  localparam logic [15:0] W_KNOWN    = 16'd100;
  localparam logic [15:0] W_UNKNOWN  = 16'd1;

  localparam int          CFG_IDX_W    = 2;
  localparam logic [1:0]  CFG_N_SIMILAR    = 2'd0;
  localparam logic [1:0]  CFG_MAIN_FACTOR  = 2'd1;
  localparam logic [1:0]  CFG_PRIOR_FACTOR = 2'd2;

  localparam logic [NSIM_W-1:0] NSIM_RESET   = 7'd25;
  localparam logic [FAC_W-1:0]  FACTOR_RESET = 16'd256;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic              in_main;
    logic              in_prior;
    logic [RANK_W-1:0] rank;
  } res_t;

endpackage

// ===== sv/masked_patch_match_select.sv =====
// ----------------------------------------------------------------------------
// masked_patch_match_select
// Sequence: an element beat is squared, weighted and accumulated; a candidate's
// final beat adds a 47-step restoring divide, then a store. The final candidate
// adds rank counting, threshold setup and emission, one memory read per step;
// emission waits while the result port stalls.
// Input: in_ready is high only while the sequencer is idle.
// Reset: synchronous active-low; clears accumulators, count and out_valid; loads register defaults.
// Weighted squared differences feed a restoring divider, a shared multiplier
// sets both thresholds, and results leave in ascending distance order.
// ----------------------------------------------------------------------------
module masked_patch_match_select #(
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpms_pkg::PIX_W-1:0]    in_ref_value,
  input  logic [mpms_pkg::PIX_W-1:0]    in_cand_value,
  input  logic                          in_ref_known,
  input  logic                          in_cand_known,
  input  logic [mpms_pkg::POS_W-1:0]    in_cand_position,
  input  logic                          in_last_element,
  input  logic                          in_last_candidate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpms_pkg::POS_W-1:0]    out_position,
  output logic                          out_in_main_group,
  output logic                          out_in_prior_group,
  output logic [mpms_pkg::RANK_W-1:0]   out_rank,
  output logic                          out_last,
  input  logic                          cfg_write_en,
  input  logic [mpms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpms_pkg::FAC_W-1:0]    cfg_data
);

  localparam int IW = $clog2(MAX_CANDIDATES);
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int XW = (CW > mpms_pkg::NSIM_W) ? CW : mpms_pkg::NSIM_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_MUL     = 5'd1;
  localparam logic [4:0] S_ACC     = 5'd2;
  localparam logic [4:0] S_DIV     = 5'd3;
  localparam logic [4:0] S_STORE   = 5'd4;
  localparam logic [4:0] S_RK_LDI  = 5'd5;
  localparam logic [4:0] S_RK_GETI = 5'd6;
  localparam logic [4:0] S_RK_LDJ  = 5'd7;
  localparam logic [4:0] S_RK_CMP  = 5'd8;
  localparam logic [4:0] S_RK_WR   = 5'd9;
  localparam logic [4:0] S_TH_ORD  = 5'd10;
  localparam logic [4:0] S_TH_DST  = 5'd11;
  localparam logic [4:0] S_TH_MUL  = 5'd12;
  localparam logic [4:0] S_TH_CHK  = 5'd13;
  localparam logic [4:0] S_TH_PA   = 5'd14;
  localparam logic [4:0] S_TH_PA2  = 5'd15;
  localparam logic [4:0] S_TH_PTH  = 5'd16;
  localparam logic [4:0] S_EM_ORD  = 5'd17;
  localparam logic [4:0] S_EM_DST  = 5'd18;
  localparam logic [4:0] S_EM_CHK  = 5'd19;
  localparam logic [4:0] S_EM_PUSH = 5'd20;
  localparam logic [4:0] S_EM_FIN  = 5'd21;

  logic [4:0] state_r, state_nxt;

  logic [mpms_pkg::NSIM_W-1:0] nsim_r;
  logic [mpms_pkg::FAC_W-1:0]  mf_r, pf_r;

  logic [mpms_pkg::PIX_W-1:0]  absd_r;
  logic                        both_r, end_r, lc_r;
  logic [mpms_pkg::POS_W-1:0]  pos_r;
  logic [mpms_pkg::PROD_W-1:0] prod_r;
  logic [mpms_pkg::DIFF_W-1:0] acc_r, quo_r;
  logic [mpms_pkg::WGT_W-1:0]  wacc_r;
  logic [mpms_pkg::WGT_W:0]    rem_r;
  logic [5:0]                  dcnt_r;
  logic [CW-1:0]               count_r, i_r, j_r, rcnt_r, sel_r, rr_r, eff_r;
  logic [mpms_pkg::DIST_W-1:0] di_r, chosen_r;
  logic [mpms_pkg::THR_W-1:0]  mth_r, pth_r;
  logic                        pend_v_r;
  mpms_pkg::res_t              pend_r, cap_r;
  logic                        out_valid_r, out_last_r;
  mpms_pkg::res_t              out_r;

  // candidate stores and sorted order
  logic [mpms_pkg::DIST_W-1:0] dist_mem [MAX_CANDIDATES];
  logic [mpms_pkg::POS_W-1:0]  pos_mem  [MAX_CANDIDATES];
  logic [IW-1:0]               ord_mem  [MAX_CANDIDATES];
  logic [mpms_pkg::DIST_W-1:0] dist_q;
  logic [mpms_pkg::POS_W-1:0]  pos_q;
  logic [IW-1:0]               ord_q;
  logic [IW-1:0]               rd_addr, ord_addr;

  // shared multiplier
  logic [mpms_pkg::FAC_W-1:0]  mul_a;
  logic [mpms_pkg::DIST_W-1:0] mul_b;
  logic                        mul_en;
  logic [mpms_pkg::PROD_W-1:0] mul_p;

  logic [38:0]                 p39, term;
  logic [mpms_pkg::DIFF_W:0]   sum_w;
  logic [mpms_pkg::DIFF_W-1:0] acc_sat;
  logic [mpms_pkg::WGT_W:0]    wsum;
  logic [mpms_pkg::WGT_W-1:0]  wsat;
  logic [mpms_pkg::WGT_W:0]    rem_sh, rem_n;
  logic                        div_ge;
  logic [mpms_pkg::DIST_W-1:0] dist_w;
  logic [XW-1:0]               nsx, nclamp;
  logic [CW-1:0]               eff_c;
  logic [mpms_pkg::THR_W-1:0]  thr_c, dq_x;
  logic                        hit_m, hit_p, slot_free, push_v, push_last;
  logic [mpms_pkg::PIX_W:0]    dif17;
  logic                        cnt_less;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  assign dif17 = {1'b0, in_ref_value} - {1'b0, in_cand_value};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state_r)
      S_MUL: begin
        mul_a  = absd_r;
        mul_b  = {16'b0, absd_r};
        mul_en = 1'b1;
      end
      S_TH_MUL: begin
        mul_a  = mf_r;
        mul_b  = dist_q;
        mul_en = 1'b1;
      end
      S_TH_PA: begin
        mul_a  = pf_r;
        mul_b  = chosen_r;
        mul_en = 1'b1;
      end
      default: ;
    endcase
  end
  assign mul_p = {32'b0, mul_a} * {16'b0, mul_b};

  // weight 100 as shift-add
  assign p39     = {7'b0, prod_r[31:0]};
  assign term    = both_r ? ((p39 << 6) + (p39 << 5) + (p39 << 2)) : p39;
  assign sum_w   = {1'b0, acc_r} + {9'b0, term};
  assign acc_sat = sum_w[mpms_pkg::DIFF_W] ? '1 : sum_w[mpms_pkg::DIFF_W-1:0];
  assign wsum    = {1'b0, wacc_r} + (both_r ? mpms_pkg::W_KNOWN : mpms_pkg::W_UNKNOWN);
  assign wsat    = wsum[mpms_pkg::WGT_W] ? '1 : wsum[mpms_pkg::WGT_W-1:0];

  // restoring divide step
  assign rem_sh = {rem_r[mpms_pkg::WGT_W-1:0], quo_r[mpms_pkg::DIFF_W-1]};
  assign div_ge = rem_sh >= {1'b0, wacc_r};
  assign rem_n  = div_ge ? (rem_sh - {1'b0, wacc_r}) : rem_sh;
  assign dist_w = (|quo_r[mpms_pkg::DIFF_W-1:mpms_pkg::DIST_W]) ? '1
                                                               : quo_r[mpms_pkg::DIST_W-1:0];

  assign nsx    = XW'(nsim_r);
  assign nclamp = (nsx < XW'(2)) ? XW'(2) : nsx;
  assign eff_c  = (nclamp > XW'(count_r)) ? count_r : CW'(nclamp);

  assign thr_c = prod_r[mpms_pkg::PROD_W-1:8];
  assign dq_x  = {8'b0, dist_q};
  assign hit_m = dq_x <= mth_r;
  assign hit_p = dq_x <= pth_r;
  assign cnt_less = (dist_q < di_r) || ((dist_q == di_r) && (j_r < i_r));

  assign push_v    = ((state_r == S_EM_PUSH) && pend_v_r && slot_free) ||
                     ((state_r == S_EM_FIN) && slot_free);
  assign push_last = (state_r == S_EM_FIN);

  always_comb begin
    rd_addr  = '0;
    ord_addr = '0;
    case (state_r)
      S_RK_LDI: rd_addr = i_r[IW-1:0];
      S_RK_LDJ: rd_addr = j_r[IW-1:0];
      S_TH_ORD: ord_addr = sel_r[IW-1:0];
      S_TH_DST: rd_addr = ord_q;
      S_TH_PA:  ord_addr = IW'(eff_r - CW'(1));
      S_TH_PA2: rd_addr = ord_q;
      S_EM_ORD: ord_addr = rr_r[IW-1:0];
      S_EM_DST: rd_addr = ord_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    dist_q <= dist_mem[rd_addr];
    pos_q  <= pos_mem[rd_addr];
    ord_q  <= ord_mem[ord_addr];
    if ((state_r == S_STORE) && (count_r < CW'(MAX_CANDIDATES))) begin
      dist_mem[count_r[IW-1:0]] <= dist_w;
      pos_mem[count_r[IW-1:0]]  <= pos_r;
    end
    if (state_r == S_RK_WR) begin
      ord_mem[rcnt_r[IW-1:0]] <= i_r[IW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_MUL;
      S_MUL:     state_nxt = S_ACC;
      S_ACC:     state_nxt = end_r ? S_DIV : S_IDLE;
      S_DIV:     if (dcnt_r == 6'(mpms_pkg::DIV_STEPS - 1)) state_nxt = S_STORE;
      S_STORE:   state_nxt = lc_r ? S_RK_LDI : S_IDLE;
      S_RK_LDI:  state_nxt = S_RK_GETI;
      S_RK_GETI: state_nxt = S_RK_LDJ;
      S_RK_LDJ:  state_nxt = S_RK_CMP;
      S_RK_CMP:  state_nxt = (j_r + CW'(1) == count_r) ? S_RK_WR : S_RK_LDJ;
      S_RK_WR:   state_nxt = (i_r + CW'(1) == count_r) ? S_TH_ORD : S_RK_LDI;
      S_TH_ORD:  state_nxt = S_TH_DST;
      S_TH_DST:  state_nxt = S_TH_MUL;
      S_TH_MUL:  state_nxt = S_TH_CHK;
      S_TH_CHK:  state_nxt = ((thr_c == '0) && (rr_r < eff_r)) ? S_TH_ORD : S_TH_PA;
      S_TH_PA:   state_nxt = S_TH_PA2;
      S_TH_PA2:  state_nxt = S_TH_PTH;
      S_TH_PTH:  state_nxt = S_EM_ORD;
      S_EM_ORD:  state_nxt = S_EM_DST;
      S_EM_DST:  state_nxt = S_EM_CHK;
      S_EM_CHK: begin
        if (hit_m || hit_p) begin
          state_nxt = S_EM_PUSH;
        end else begin
          state_nxt = (rr_r + CW'(1) == count_r) ? S_EM_FIN : S_EM_ORD;
        end
      end
      S_EM_PUSH: begin
        if (!pend_v_r || slot_free) begin
          state_nxt = (rr_r + CW'(1) == count_r) ? S_EM_FIN : S_EM_ORD;
        end
      end
      S_EM_FIN:  if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_p;
    case (state_r)
      S_IDLE: begin
        absd_r <= dif17[mpms_pkg::PIX_W] ? (in_cand_value - in_ref_value)
                                         : dif17[mpms_pkg::PIX_W-1:0];
        both_r <= in_ref_known && in_cand_known;
        end_r  <= in_last_element || in_last_candidate;
        lc_r   <= in_last_candidate;
        pos_r  <= in_cand_position;
      end
      S_ACC: begin
        quo_r  <= acc_sat;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        rem_r  <= rem_n;
        quo_r  <= {quo_r[mpms_pkg::DIFF_W-2:0], div_ge};
        dcnt_r <= dcnt_r + 6'd1;
      end
      S_RK_GETI: begin
        di_r   <= dist_q;
        j_r    <= '0;
        rcnt_r <= '0;
      end
      S_RK_CMP: begin
        if (cnt_less) rcnt_r <= rcnt_r + CW'(1);
        j_r <= j_r + CW'(1);
      end
      S_RK_WR: begin
        if (i_r + CW'(1) == count_r) begin
          sel_r <= (count_r >= CW'(2)) ? CW'(1) : CW'(0);
        end
      end
      S_TH_MUL: chosen_r <= dist_q;
      S_TH_CHK: begin
        mth_r <= thr_c;
        if ((thr_c == '0) && (rr_r < eff_r)) begin
          sel_r <= rr_r;
        end
      end
      S_TH_PTH: pth_r <= (thr_c > dq_x) ? thr_c : dq_x;
      S_EM_CHK: cap_r <= '{pos: pos_q, in_main: hit_m, in_prior: hit_p,
                           rank: mpms_pkg::RANK_W'(rr_r)};
      default: ;
    endcase
    if (push_v) begin
      out_r      <= pend_r;
      out_last_r <= push_last;
    end
    if ((state_r == S_EM_PUSH) && (!pend_v_r || slot_free)) pend_r <= cap_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nsim_r      <= mpms_pkg::NSIM_RESET;
      mf_r        <= mpms_pkg::FACTOR_RESET;
      pf_r        <= mpms_pkg::FACTOR_RESET;
      acc_r       <= '0;
      wacc_r      <= '0;
      count_r     <= '0;
      i_r         <= '0;
      rr_r        <= '0;
      eff_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          mpms_pkg::CFG_N_SIMILAR:    nsim_r <= cfg_data[mpms_pkg::NSIM_W-1:0];
          mpms_pkg::CFG_MAIN_FACTOR:  mf_r   <= cfg_data;
          mpms_pkg::CFG_PRIOR_FACTOR: pf_r   <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_ACC: begin
          acc_r  <= acc_sat;
          wacc_r <= wsat;
        end
        S_STORE: begin
          acc_r  <= '0;
          wacc_r <= '0;
          if (count_r < CW'(MAX_CANDIDATES)) count_r <= count_r + CW'(1);
          i_r <= '0;
        end
        S_RK_WR: begin
          i_r <= i_r + CW'(1);
          if (i_r + CW'(1) == count_r) begin
            rr_r  <= CW'(2);
            eff_r <= eff_c;
          end
        end
        S_TH_CHK: begin
          if ((thr_c == '0) && (rr_r < eff_r)) rr_r <= rr_r + CW'(1);
        end
        S_TH_PTH: rr_r <= '0;
        S_EM_CHK: begin
          if (!(hit_m || hit_p)) rr_r <= rr_r + CW'(1);
        end
        S_EM_PUSH: begin
          if (!pend_v_r || slot_free) begin
            rr_r     <= rr_r + CW'(1);
            pend_v_r <= 1'b1;
          end
        end
        S_EM_FIN: begin
          if (slot_free) begin
            pend_v_r <= 1'b0;
            count_r  <= '0;
          end
        end
        default: ;
      endcase
      if (push_v) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position       = out_r.pos;
  assign out_in_main_group  = out_r.in_main;
  assign out_in_prior_group = out_r.in_prior;
  assign out_rank           = out_r.rank;
  assign out_last           = out_last_r;

endmodule

// ===== sv/mpms_checker.sv =====
// ----------------------------------------------------------------------------
// mpms_assert
// Port-level checks for masked_patch_match_select, bound to the top level.
// ----------------------------------------------------------------------------
module mpms_assert (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_last_candidate,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mpms_pkg::POS_W-1:0]     out_position,
  input logic [mpms_pkg::RANK_W-1:0]    out_rank,
  input logic                           out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) &&
                                $stable(out_rank) && $stable(out_last))
    else $error("result beat changed while stalled");

  // each input beat keeps the sequencer busy for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a closing beat starts selection, so the sequencer stays busy after it
  a_select: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_candidate |=> ##1 !in_ready)
    else $error("selection skipped after closing beat");

endmodule

bind masked_patch_match_select mpms_assert u_mpms_assert (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_last_candidate (in_last_candidate),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_position      (out_position),
  .out_rank          (out_rank),
  .out_last          (out_last)
);

// ===== dv/mpms_checker.sv =====
// ----------------------------------------------------------------------------
// mpms_checker
// Watches the element, result and register ports of the patch-match
// selector. It keeps its own accumulators, candidate store and registers,
// ranks the candidates when a run closes, and checks each result beat
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module mpms_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [mpms_pkg::PIX_W-1:0]     in_ref_value,
  input  logic [mpms_pkg::PIX_W-1:0]     in_cand_value,
  input  logic                           in_ref_known,
  input  logic                           in_cand_known,
  input  logic [mpms_pkg::POS_W-1:0]     in_cand_position,
  input  logic                           in_last_element,
  input  logic                           in_last_candidate,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [mpms_pkg::POS_W-1:0]     out_position,
  input  logic                           out_in_main_group,
  input  logic                           out_in_prior_group,
  input  logic [mpms_pkg::RANK_W-1:0]    out_rank,
  input  logic                           out_last,
  input  logic                           cfg_write_en,
  input  logic [mpms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpms_pkg::FAC_W-1:0]     cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             results_seen,
  output int                             runs_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam longint unsigned DIFF_SAT = (64'd1 << mpms_pkg::DIFF_W) - 1;
  localparam longint unsigned WGT_SAT  = (64'd1 << mpms_pkg::WGT_W) - 1;
  localparam longint unsigned DIST_SAT = 64'hFFFF_FFFF;

  typedef struct packed {
    mpms_pkg::res_t body;
    logic           last;
  } sel_beat_t;

  sel_beat_t                   selected_q[$];
  logic [mpms_pkg::NSIM_W-1:0] n_similar;
  logic [mpms_pkg::FAC_W-1:0]  main_factor;
  logic [mpms_pkg::FAC_W-1:0]  prior_factor;
  longint unsigned             diff_acc;
  longint unsigned             wgt_acc;
  longint unsigned             dist_mem[SLOTS];
  logic [mpms_pkg::POS_W-1:0]  pos_mem[SLOTS];
  int                          cand_cnt;

  always @(posedge clk) begin
    sel_beat_t       exp_b;
    sel_beat_t       run_q[$];
    int              order[SLOTS];
    longint signed   delta;
    longint unsigned w, q, chosen, mth, pth, pa, d;
    int              n, eff, r, t, j;
    if (!rst_n) begin
      n_similar    = mpms_pkg::NSIM_RESET;
      main_factor  = mpms_pkg::FACTOR_RESET;
      prior_factor = mpms_pkg::FACTOR_RESET;
      diff_acc     = 0;
      wgt_acc      = 0;
      cand_cnt     = 0;
      selected_q.delete();
      mismatches   = 0;
      results_seen = 0;
      runs_seen    = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (selected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat pos=%h rank=%0d", $time,
                     out_position, out_rank);
        end else begin
          exp_b = selected_q.pop_front();
          if (exp_b.body.pos !== out_position || exp_b.body.in_main !== out_in_main_group ||
              exp_b.body.in_prior !== out_in_prior_group ||
              exp_b.body.rank !== out_rank || exp_b.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch exp pos=%h main=%b prior=%b rank=%0d last=%b",
                       $time, exp_b.body.pos, exp_b.body.in_main, exp_b.body.in_prior,
                       exp_b.body.rank, exp_b.last,
                       " / got pos=%h main=%b prior=%b rank=%0d last=%b",
                       out_position, out_in_main_group, out_in_prior_group,
                       out_rank, out_last);
          end
        end
      end

      if (cfg_write_en) begin
        case (cfg_index)
          mpms_pkg::CFG_N_SIMILAR:    n_similar    = cfg_data[mpms_pkg::NSIM_W-1:0];
          mpms_pkg::CFG_MAIN_FACTOR:  main_factor  = cfg_data;
          mpms_pkg::CFG_PRIOR_FACTOR: prior_factor = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        delta = longint'(in_ref_value) - longint'(in_cand_value);
        w = (in_ref_known && in_cand_known) ? 64'(mpms_pkg::W_KNOWN)
                                            : 64'(mpms_pkg::W_UNKNOWN);
        diff_acc += longint'(delta * delta) * w;
        if (diff_acc > DIFF_SAT) diff_acc = DIFF_SAT;
        wgt_acc += w;
        if (wgt_acc > WGT_SAT) wgt_acc = WGT_SAT;

        // a run's final beat closes its candidate even without last_element
        if (in_last_element || in_last_candidate) begin
          q = diff_acc / wgt_acc;
          if (q > DIST_SAT) q = DIST_SAT;
          if (cand_cnt < SLOTS) begin
            dist_mem[cand_cnt] = q;
            pos_mem[cand_cnt]  = in_cand_position;
            cand_cnt++;
          end
          diff_acc = 0;
          wgt_acc  = 0;
        end

        if (in_last_candidate) begin
          n = cand_cnt;
          runs_seen++;
          // stable insertion sort, ties keep arrival order
          for (int i = 0; i < n; i++) order[i] = i;
          for (int i = 1; i < n; i++) begin
            t = order[i];
            j = i;
            while (j > 0 && dist_mem[order[j-1]] > dist_mem[t]) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = t;
          end
          eff = n_similar;
          if (eff < 2) eff = 2;
          if (eff > n) eff = n;
          chosen = dist_mem[order[(n >= 2) ? 1 : 0]];
          mth = (64'(main_factor) * chosen) >> 8;
          r = 2;
          while (mth == 0 && r < eff) begin
            chosen = dist_mem[order[r]];
            mth = (64'(main_factor) * chosen) >> 8;
            r++;
          end
          pa  = (64'(prior_factor) * chosen) >> 8;
          d   = dist_mem[order[eff-1]];
          pth = (pa > d) ? pa : d;
          run_q.delete();
          for (int k = 0; k < n; k++) begin
            d = dist_mem[order[k]];
            if (d <= mth || d <= pth) begin
              exp_b.body.pos      = pos_mem[order[k]];
              exp_b.body.in_main  = (d <= mth);
              exp_b.body.in_prior = (d <= pth);
              exp_b.body.rank     = k[mpms_pkg::RANK_W-1:0];
              exp_b.last          = 1'b0;
              run_q.push_back(exp_b);
            end
          end
          if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
          foreach (run_q[k]) selected_q.push_back(run_q[k]);
          diff_acc = 0;
          wgt_acc  = 0;
          cand_cnt = 0;
        end
      end
    end
    pending = selected_q.size();
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives candidate runs into the patch-match selector with bursty input and
// a stalling result port, steps the three registers through their extremes
// between runs, and takes the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = mpms_pkg::PIX_W;
  localparam int QW = mpms_pkg::POS_W;
  localparam int FW = mpms_pkg::FAC_W;
  localparam int IXW = mpms_pkg::CFG_IDX_W;
  localparam logic [IXW-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 100;

  logic              clk, rst_n;
  logic              in_valid, in_ready;
  logic [PW-1:0]     in_ref_value, in_cand_value;
  logic              in_ref_known, in_cand_known;
  logic [QW-1:0]     in_cand_position;
  logic              in_last_element, in_last_candidate;
  logic              out_valid, out_ready;
  logic [QW-1:0]     out_position;
  logic              out_in_main_group, out_in_prior_group, out_last;
  logic [mpms_pkg::RANK_W-1:0] out_rank;
  logic              cfg_write_en;
  logic [IXW-1:0]    cfg_index;
  logic [FW-1:0]     cfg_data;

  int mismatches, pending, results_seen, runs_seen;
  int items_sent, burst_left, idle_cycles, reg_writes;
  bit hold_req;

  masked_patch_match_select DUT (.*);

  mpms_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // no-progress watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result port: changing stall patterns, one long hold-off on request
  initial begin
    int mode, span;
    out_ready = 0;
    span = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 80);
      end
      span--;
      case (mode)
        0: out_ready = 1;
        1: out_ready = 1'($urandom_range(0, 1));
        2: out_ready = ($urandom_range(0, 4) == 0);
        default: out_ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_beat(input logic [PW-1:0] rv, cv, input logic rk, ck,
                           input logic [QW-1:0] pos, input logic le, lc);
    @(negedge clk);
    in_valid = 1;
    in_ref_value = rv;
    in_cand_value = cv;
    in_ref_known = rk;
    in_cand_known = ck;
    in_cand_position = pos;
    in_last_element = le;
    in_last_candidate = lc;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // mode 0: full-range pixels, 1: tiny range (ties), 2: identical pixels
  task automatic send_cand(input int nel, input int mode, input bit fin, input bit broken);
    logic [PW-1:0] rv, cv;
    for (int k = 0; k < nel; k++) begin
      rv = (mode == 1) ? PW'($urandom_range(0, 3)) : PW'($urandom);
      cv = (mode == 2) ? rv : ((mode == 1) ? PW'($urandom_range(0, 3)) : PW'($urandom));
      send_beat(rv, cv, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), QW'($urandom),
                (k == nel - 1) && !(fin && broken), fin && (k == nel - 1));
    end
  endtask

  task automatic send_run(input int ncand, input int max_el);
    for (int c = 0; c < ncand; c++)
      send_cand($urandom_range(1, max_el), $urandom_range(0, 2), c == ncand - 1,
                $urandom_range(0, 5) == 0);
  endtask

  // drop valid, drain results, let the selector finish
  task automatic settle();
    @(negedge clk);
    in_valid = 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IXW-1:0] idx, input logic [FW-1:0] val);
    @(negedge clk);
    cfg_write_en = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write_en = 0;
    reg_writes++;
  endtask

  function automatic logic [FW-1:0] pick_value(input logic [IXW-1:0] idx);
    case ($urandom_range(0, 5))
      0: return FW'(0);
      1: return FW'(1);
      2: return 16'hFFFF;
      3: return (idx == mpms_pkg::CFG_N_SIMILAR) ? FW'(2) : FW'(256);
      4: return (idx == mpms_pkg::CFG_N_SIMILAR) ? FW'($urandom_range(2, 10))
                                                 : FW'($urandom_range(1, 1024));
      default: return FW'($urandom);
    endcase
  endfunction

  initial begin
    int target, ncand;
    logic [IXW-1:0] idx;
    rst_n = 0;
    in_valid = 0;
    in_ref_value = 0;
    in_cand_value = 0;
    in_ref_known = 0;
    in_cand_known = 0;
    in_cand_position = 0;
    in_last_element = 0;
    in_last_candidate = 0;
    cfg_write_en = 0;
    cfg_index = 0;
    cfg_data = 0;
    hold_req = 0;
    items_sent = 0;
    burst_left = 0;
    reg_writes = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // lone candidate, extreme pixels and position
    send_beat(16'hFFFF, 16'h0000, 1, 1, 24'hFFFFFF, 1, 1);
    // all-zero distances: main threshold walks up the ranks
    send_cand(2, 2, 0, 0);
    send_cand(1, 2, 0, 0);
    send_cand(2, 2, 1, 0);
    // run closes on a beat without last_element
    send_cand(3, 0, 0, 0);
    send_cand(2, 0, 1, 1);
    settle();
    write_reg(mpms_pkg::CFG_MAIN_FACTOR, 16'h0000);
    write_reg(mpms_pkg::CFG_PRIOR_FACTOR, 16'h0000);
    write_reg(mpms_pkg::CFG_N_SIMILAR, 16'h0000);
    send_run(4, 3);
    settle();
    write_reg(mpms_pkg::CFG_N_SIMILAR, 16'h007F);
    write_reg(mpms_pkg::CFG_MAIN_FACTOR, 16'hFFFF);
    write_reg(mpms_pkg::CFG_PRIOR_FACTOR, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'h0001);
    send_run(5, 3);
    // results held back through selection while the next run queues up
    hold_req = 1;
    send_run(3, 2);
    settle();
    write_reg(mpms_pkg::CFG_N_SIMILAR, 16'h0001);
    write_reg(mpms_pkg::CFG_MAIN_FACTOR, 16'h0100);
    write_reg(mpms_pkg::CFG_PRIOR_FACTOR, 16'h0100);
    // long patch with maximal differences
    for (int k = 0; k < 100; k++) send_beat(16'hFFFF, 16'h0000, 1, 1, QW'(k), k == 99, 0);
    send_cand(2, 0, 1, 0);
    // more candidates than the store holds
    send_run(70, 1);

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        repeat ($urandom_range(1, 3)) begin
          idx = ($urandom_range(0, 9) == 0) ? CFG_UNUSED : IXW'($urandom_range(0, 2));
          write_reg(idx, pick_value(idx));
        end
      end
      ncand = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      send_run(ncand, (ncand > 20) ? 1 : 5);
    end

    settle();
    repeat (200) @(negedge clk);
    $display("Ran %0d element beats in %0d runs with %0d register writes;", items_sent,
             runs_seen, reg_writes);
    $display("checked %0d result beats, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
